// ===== sv/rsd_pkg.sv =====
// rsd_pkg: shared types and constants for the rrip/ship/dip replacement block
// no dependencies
package rsd_pkg;

  // cache geometry, fixed by the request field widths
  localparam int unsigned NUM_SETS = 2048;
  localparam int unsigned NUM_WAYS = 16;
  localparam int unsigned SET_W = $clog2(NUM_SETS);
  localparam int unsigned WAY_W = $clog2(NUM_WAYS);

  localparam int unsigned RRPV_MAX = 3;
  localparam int unsigned STREAK_MAX = 255;
  localparam int unsigned SIG_SHIFT = 6;
  localparam logic [7:0] THRESH_RESET = 8'd8;

  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS = 2'd1;
  localparam logic [1:0] SIGN_NEG = 2'd3;

  localparam logic FUNC_FIND = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

endpackage

// ===== sv/rsd_clear.sv =====
// rsd_clear: post-reset sweep counter that walks every set once
// depends on rsd_pkg
module rsd_clear #(
  parameter int unsigned SET_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  output logic             busy,
  output logic [SET_W-1:0] addr
);
  import rsd_pkg::*;

  logic [SET_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == {SET_W{1'b1}}) busy <= 1'b0;
    end
  end

  assign addr = count;

endmodule

// ===== sv/rrip_ship_dip_replacement.sv =====
// rrip_ship_dip_replacement: top level of the replacement policy block
// depends on rsd_pkg and rsd_clear
//
// channel  dir  fields
// s_axis   in   tuser: func; tdata: set_index, way, addr, pc, hit, chance
// m_axis   out  tdata: victim_way, insert_value
// cfg      in   stream_threshold write
//
// steps per request: accept + row/counter read, old-signature counter read,
//   decide + counter write, result shown + row write back once the result is taken
// reset: clearing pass over max(NUM_SETS, 2^SIG_BITS) addresses (2048 by default) of the
//   set and counter memories, no request taken until it ends
// stalls: a waiting result holds the sequencer, and no new request is taken while it waits
module rrip_ship_dip_replacement #(
  parameter int unsigned SIG_BITS = 6,
  parameter int unsigned SEL_BITS = 10,
  parameter int unsigned LEADERS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[0]
  input  logic         s_axis_tuser,
  // set_index[10:0], way[14:11], addr[78:15], pc[142:79], hit[143], chance[148:144]
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // victim_way[3:0], insert_value[5:4]
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);
  import rsd_pkg::*;

  localparam int unsigned SIG_N = 1 << SIG_BITS;
  localparam int unsigned STRIDE = NUM_SETS / LEADERS;
  localparam int unsigned HALF = STRIDE / 2;
  localparam int unsigned CLR_W = (SET_W > SIG_BITS) ? SET_W : SIG_BITS;
  localparam logic [SEL_BITS-1:0] SEL_MAXV = {SEL_BITS{1'b1}};
  localparam logic [SEL_BITS-1:0] SEL_MIDV = SEL_BITS'(1) << (SEL_BITS - 1);

  // field positions in s_axis_tdata
  localparam int unsigned F_SET = 0;
  localparam int unsigned F_WAY = 11;
  localparam int unsigned F_ADDR = 15;
  localparam int unsigned F_PC = 79;
  localparam int unsigned F_HIT = 143;
  localparam int unsigned F_CHANCE = 144;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_RD = 4'b0010, S_CALC = 4'b0100, S_OUT = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0] sign;
    logic [7:0] streak;
    logic [63:0] last;
  } hist_t;

  state_t state;

  // set-row memories: rrpv row, signature row, history; reuse counters by signature
  logic [2*NUM_WAYS-1:0] rrpv_mem [NUM_SETS];
  logic [SIG_BITS*NUM_WAYS-1:0] sig_mem [NUM_SETS];
  hist_t hist_mem [NUM_SETS];
  logic [1:0] ctr_mem [SIG_N];

  logic [2*NUM_WAYS-1:0] rrpv_q, rrpv_w, wr_rrpv;
  logic [SIG_BITS*NUM_WAYS-1:0] sig_q, sig_w, wr_sig;
  hist_t hist_q, hist_w, wr_hist;
  logic [SET_W-1:0] rd_set, wr_set;
  logic wr_en;

  logic [1:0] ctr_a_q, ctr_b_q, ctr_wd;
  logic [SIG_BITS-1:0] ctr_ra, ctr_wa;
  logic ctr_we;

  logic clr_busy;
  logic [CLR_W-1:0] clr_addr;
  rsd_clear #(.SET_W(CLR_W)) u_clear (.clk(clk), .rst(rst), .busy(clr_busy), .addr(clr_addr));

  // request fields
  logic func_r, hit_r;
  logic [SET_W-1:0] set_r;
  logic [WAY_W-1:0] way_r;
  logic [63:0] addr_r;
  logic [SIG_BITS-1:0] sig_in, sig_r, old_sig;
  logic [4:0] chance_r;
  logic [7:0] thresh;
  logic [SEL_BITS-1:0] sel, sel_next;
  logic [WAY_W-1:0] victim, victim_next;
  logic [1:0] ins, ins_c, ins_next;
  logic [2*NUM_WAYS-1:0] rrpv_next;
  logic [SIG_BITS*NUM_WAYS-1:0] sig_next;
  hist_t hist_next;

  assign s_axis_tready = (state == S_IDLE) && !clr_busy;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {2'b00, ins, victim};

  assign sig_in = SIG_BITS'(s_axis_tdata[F_PC +: 64] ^ (s_axis_tdata[F_ADDR +: 64] >> SIG_SHIFT));

  always_ff @(posedge clk) begin
    if (rst) thresh <= THRESH_RESET;
    else if (cfg_wr_en) thresh <= cfg_wr_data;
  end

  // memories: one read, one write port each; address held on the captured set after accept
  assign rd_set = s_axis_tready ? s_axis_tdata[F_SET +: SET_W] : set_r;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rrpv_mem[wr_set] <= wr_rrpv;
      sig_mem[wr_set] <= wr_sig;
      hist_mem[wr_set] <= wr_hist;
    end
    rrpv_q <= rrpv_mem[rd_set];
    sig_q <= sig_mem[rd_set];
    hist_q <= hist_mem[rd_set];
  end

  // counter memory: port a reads the new signature, port b the evicted line's signature
  assign ctr_ra = s_axis_tready ? sig_in : sig_r;
  assign old_sig = sig_q[SIG_BITS*way_r +: SIG_BITS];
  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    ctr_a_q <= ctr_mem[ctr_ra];
    ctr_b_q <= ctr_mem[old_sig];
  end

  // counter write: zero during clearing; on an update, train on a hit, drop the evicted signature on a fill
  always_comb begin
    ctr_we = 1'b0;
    ctr_wa = sig_r;
    ctr_wd = 2'd0;
    if (clr_busy) begin
      ctr_we = 1'b1;
      ctr_wa = clr_addr[SIG_BITS-1:0];
    end else if (state == S_CALC && func_r == FUNC_UPDATE) begin
      ctr_we = 1'b1;
      if (hit_r) begin
        ctr_wa = sig_r;
        ctr_wd = (ctr_a_q < 2'd3) ? ctr_a_q + 2'd1 : ctr_a_q;
      end else begin
        ctr_wa = old_sig;
        ctr_wd = (ctr_b_q > 2'd0) ? ctr_b_q - 2'd1 : ctr_b_q;
      end
    end
  end

  // leader detection; a set that is both counts as lip for the insertion choice
  logic lip_l, bip_l;
  always_comb begin
    lip_l = 1'b0;
    bip_l = 1'b0;
    for (int i = 0; i < LEADERS; i++) begin
      if (set_r == SET_W'(i * STRIDE)) lip_l = 1'b1;
      if (set_r == SET_W'(i * STRIDE + HALF)) bip_l = 1'b1;
    end
  end

  // aging and victim search on the registered row
  logic [1:0] top, add;
  logic [2*NUM_WAYS-1:0] aged;
  logic [WAY_W-1:0] vic_c;
  always_comb begin
    top = '0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (rrpv_q[2*w +: 2] > top) top = rrpv_q[2*w +: 2];
    add = 2'(RRPV_MAX) - top;
    vic_c = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      aged[2*w +: 2] = rrpv_q[2*w +: 2] + add;
      if (aged[2*w +: 2] == 2'(RRPV_MAX)) vic_c = WAY_W'(w);
    end
  end

  // history update
  hist_t hist_c;
  logic [63:0] diff;
  logic [1:0] sgn;
  always_comb begin
    hist_c = hist_q;
    diff = addr_r - hist_q.last;
    sgn = (diff == 64'd0) ? SIGN_NONE : (diff[63] ? SIGN_NEG : SIGN_POS);
    if (hist_q.last != 64'd0) begin
      if (sgn != SIGN_NONE && sgn == hist_q.sign) begin
        if (hist_q.streak < 8'(STREAK_MAX)) hist_c.streak = hist_q.streak + 8'd1;
      end else hist_c.streak = 8'd1;
      hist_c.sign = sgn;
    end
    hist_c.last = addr_r;
  end

  // insertion value on a fill: streaming, predicted reuse, then lip/bip
  always_comb begin
    priority if (hist_c.streak >= thresh) ins_c = 2'(RRPV_MAX);
    else if (ctr_a_q >= 2'd2) ins_c = 2'd0;
    else if (lip_l || (!bip_l && sel >= SEL_MIDV)) ins_c = 2'(RRPV_MAX);
    else ins_c = (chance_r == 5'd0) ? 2'd0 : 2'(RRPV_MAX);
  end

  // next row, result and selector values
  always_comb begin
    rrpv_next = rrpv_q;
    sig_next = sig_q;
    hist_next = hist_c;
    victim_next = '0;
    ins_next = 2'd0;
    sel_next = sel;
    if (func_r == FUNC_FIND) begin
      rrpv_next = aged;
      victim_next = vic_c;
      hist_next = hist_q;
    end else begin
      sig_next[SIG_BITS*way_r +: SIG_BITS] = sig_r;
      if (hit_r) begin
        rrpv_next[2*way_r +: 2] = 2'd0;
        if (lip_l && sel < SEL_MAXV) sel_next = sel + 1'b1;
        else if (bip_l && sel > '0) sel_next = sel - 1'b1;
      end else begin
        rrpv_next[2*way_r +: 2] = ins_c;
        ins_next = ins_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= SEL_MIDV;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func_r <= s_axis_tuser;
            set_r <= s_axis_tdata[F_SET +: SET_W];
            way_r <= s_axis_tdata[F_WAY +: WAY_W];
            addr_r <= s_axis_tdata[F_ADDR +: 64];
            sig_r <= sig_in;
            hit_r <= s_axis_tdata[F_HIT];
            chance_r <= s_axis_tdata[F_CHANCE +: 5];
            state <= S_RD;
          end
        end
        S_RD: state <= S_CALC;
        S_CALC: begin
          hist_w <= hist_next;
          rrpv_w <= rrpv_next;
          sig_w <= sig_next;
          victim <= victim_next;
          ins <= ins_next;
          sel <= sel_next;
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // write back when the result is taken; during clearing write reset rows
  always_comb begin
    wr_en = clr_busy || (state == S_OUT && m_axis_tready);
    wr_set = clr_busy ? clr_addr[SET_W-1:0] : set_r;
    wr_rrpv = clr_busy ? {NUM_WAYS{2'(RRPV_MAX)}} : rrpv_w;
    wr_sig = clr_busy ? '0 : sig_w;
    wr_hist = clr_busy ? '0 : hist_w;
  end

  a_out_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result waits");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_sel: assert property (@(posedge clk) disable iff (rst)
    (state != S_CALC) |=> $stable(sel)) else $error("selector change");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_axis_tready) else $error("accept during clear");
  a_state: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");

endmodule
